/* rtl/core/srfc_pkg.sv */
// Shared types, constants and CRC function for the sensor response frame checker.
`timescale 1ns / 1ps
`default_nettype none

package srfc_pkg;

	localparam logic [15:0] CRC_INIT     = 16'hFFFF;
	localparam logic [15:0] CRC_POLY     = 16'hA001;
	localparam logic [7:0]  HEADER_BYTE0 = 8'h03;
	localparam logic [7:0]  HEADER_BYTE1 = 8'h04;
	localparam logic [2:0]  POS_LAST_CRC = 3'd5;

	typedef enum logic [2:0] {
		POS_HDR0  = 3'd0,
		POS_HDR1  = 3'd1,
		POS_HUM_H = 3'd2,
		POS_HUM_L = 3'd3,
		POS_TMP_H = 3'd4,
		POS_TMP_L = 3'd5,
		POS_CRC_L = 3'd6,
		POS_CRC_H = 3'd7
	} srfc_pos_t;

	typedef enum logic [1:0] {
		STATUS_OK     = 2'd0,
		STATUS_HEADER = 2'd1,
		STATUS_CRC    = 2'd2
	} srfc_status_t;

	typedef struct packed {
		logic [7:0] data_byte;
		logic       frame_start;
	} srfc_byte_t;

	typedef struct packed {
		logic       valid;
		srfc_byte_t payload;
	} srfc_s1_t;

	// Byte-parallel CRC-16/MODBUS update, reflected polynomial.
	function automatic logic [15:0] crc_feed(input logic [15:0] crc, input logic [7:0] b);
		logic [15:0] c;
		c = crc ^ {8'h00, b};
		for (int k = 0; k < 8; k++) begin
			if (c[0]) begin
				c = (c >> 1) ^ CRC_POLY;
			end else begin
				c = c >> 1;
			end
		end
		return c;
	endfunction

endpackage

`default_nettype wire

/* rtl/core/srfc_stream_if.sv */
// Valid/ready channel interfaces for the byte input and the result output.
`timescale 1ns / 1ps
`default_nettype none

interface srfc_byte_if;
	logic       valid;
	logic       ready;
	logic [7:0] data_byte;
	logic       frame_start;

	modport source (output valid, output data_byte, output frame_start, input ready);
	modport sink   (input valid, input data_byte, input frame_start, output ready);
endinterface

interface srfc_result_if;
	logic               valid;
	logic               ready;
	logic [1:0]         frame_status;
	logic signed [15:0] temperature_tenths;
	logic [15:0]        humidity_tenths;

	modport source (output valid, output frame_status, output temperature_tenths,
		output humidity_tenths, input ready);
	modport sink   (input valid, input frame_status, input temperature_tenths,
		input humidity_tenths, output ready);
endinterface

`default_nettype wire

/* rtl/core/sensor_response_frame_checker.sv */
// Sensor reply frame checker: header and CRC-16 check, readings in tenths.
// A result is registered after the frame's last byte passes the input register.
// One byte per cycle via the byte-wide CRC update, while no last byte is held.
// The input keeps accepting while a result waits, until the next frame's last byte.
// Reset (arst_n low, asynchronous): position 0, CRC 0xFFFF, no result pending.
`timescale 1ns / 1ps
`default_nettype none

module sensor_response_frame_checker (
	input  wire logic     clk,
	input  wire logic     arst_n,
	srfc_byte_if.sink     byte_in,
	srfc_result_if.source result_out
);
	import srfc_pkg::*;

	srfc_s1_t s1;
	logic     take;

	srfc_in_stage u_in_stage (
		.clk     (clk),
		.arst_n  (arst_n),
		.byte_in (byte_in),
		.take    (take),
		.s1      (s1)
	);

	srfc_frame_core u_frame_core (
		.clk        (clk),
		.arst_n     (arst_n),
		.s1         (s1),
		.take       (take),
		.result_out (result_out)
	);

endmodule

`default_nettype wire

/* rtl/core/srfc_in_stage.sv */
// Input register stage: one byte per cycle unless held by the core.
`timescale 1ns / 1ps
`default_nettype none

module srfc_in_stage (
	input  wire logic             clk,
	input  wire logic             arst_n,
	srfc_byte_if.sink             byte_in,
	input  wire logic             take,
	output srfc_pkg::srfc_s1_t    s1
);
	import srfc_pkg::*;

	logic       valid_s1;
	srfc_byte_t payload_s1;

	assign byte_in.ready = !valid_s1 || take;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (byte_in.ready) begin
			valid_s1 <= byte_in.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (byte_in.ready && byte_in.valid) begin
			payload_s1.data_byte   <= byte_in.data_byte;
			payload_s1.frame_start <= byte_in.frame_start;
		end
	end

	assign s1.valid   = valid_s1;
	assign s1.payload = payload_s1;

endmodule

`default_nettype wire

/* rtl/core/srfc_frame_core.sv */
// Frame state, CRC update, checks and result register.
`timescale 1ns / 1ps
`default_nettype none

module srfc_frame_core (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire srfc_pkg::srfc_s1_t s1,
	output logic                  take,
	srfc_result_if.source         result_out
);
	import srfc_pkg::*;

	srfc_pos_t    pos_q;
	logic [15:0]  crc_q;
	logic         hdr_bad_q;
	logic [15:0]  hum_q;
	logic [15:0]  tmp_q;
	logic [7:0]   crc_low_q;

	logic               out_valid_q;
	srfc_status_t       status_q;
	logic signed [15:0] temp_q;
	logic [15:0]        humid_q;

	srfc_pos_t          pos;
	logic [7:0]         b;
	logic [15:0]        crc_base;
	logic [15:0]        crc_next;
	logic               hdr_bad_next;
	logic               emit;
	logic               slot_free;
	srfc_status_t       status;
	logic [15:0]        received;
	logic [15:0]        mag;
	logic signed [15:0] temp_val;

	assign b    = s1.payload.data_byte;
	assign pos  = s1.payload.frame_start ? POS_HDR0 : pos_q;
	assign emit = (pos == POS_CRC_H);

	assign slot_free = !out_valid_q || result_out.ready;
	assign take      = s1.valid && (!emit || slot_free);

	always_comb begin
		crc_base = (pos == POS_HDR0) ? CRC_INIT : crc_q;
		crc_next = (pos <= POS_LAST_CRC) ? crc_feed(crc_base, b) : crc_base;
		case (pos)
			POS_HDR0: hdr_bad_next = (b != HEADER_BYTE0);
			POS_HDR1: hdr_bad_next = hdr_bad_q || (b != HEADER_BYTE1);
			default:  hdr_bad_next = hdr_bad_q;
		endcase
	end

	// Header is checked ahead of the CRC.
	always_comb begin
		received = {b, crc_low_q};
		if (hdr_bad_q) begin
			status = STATUS_HEADER;
		end else if (received != crc_q) begin
			status = STATUS_CRC;
		end else begin
			status = STATUS_OK;
		end
		mag      = {1'b0, tmp_q[14:0]};
		temp_val = tmp_q[15] ? -$signed(mag) : $signed(mag);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q     <= POS_HDR0;
			crc_q     <= CRC_INIT;
			hdr_bad_q <= 1'b0;
			hum_q     <= '0;
			tmp_q     <= '0;
			crc_low_q <= '0;
		end else if (take) begin
			pos_q     <= srfc_pos_t'(pos + 3'd1);
			crc_q     <= emit ? CRC_INIT : crc_next;
			hdr_bad_q <= hdr_bad_next;
			case (pos)
				POS_HUM_H: hum_q[15:8] <= b;
				POS_HUM_L: hum_q[7:0]  <= b;
				POS_TMP_H: tmp_q[15:8] <= b;
				POS_TMP_L: tmp_q[7:0]  <= b;
				POS_CRC_L: crc_low_q   <= b;
				default:   ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (take && emit) begin
			out_valid_q <= 1'b1;
		end else if (result_out.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	// Zero the readings on any error.
	always_ff @(posedge clk) begin
		if (take && emit) begin
			status_q <= status;
			temp_q   <= (status == STATUS_OK) ? temp_val : 16'sd0;
			humid_q  <= (status == STATUS_OK) ? hum_q : 16'd0;
		end
	end

	assign result_out.valid              = out_valid_q;
	assign result_out.frame_status       = status_q;
	assign result_out.temperature_tenths = temp_q;
	assign result_out.humidity_tenths    = humid_q;

endmodule

`default_nettype wire

/* rtl/core/srfc_checker.sv */
// Port-level checks for the sensor reply frame checker, bound to the top level.
`timescale 1ns / 1ps
`default_nettype none

module srfc_checker (
	input wire logic        clk,
	input wire logic        arst_n,
	input wire logic        in_valid,
	input wire logic        in_ready,
	input wire logic        out_valid,
	input wire logic        out_ready,
	input wire logic [1:0]  frame_status,
	input wire logic [15:0] temperature_tenths,
	input wire logic [15:0] humidity_tenths
);
	import srfc_pkg::*;

	// Hold a pending result until it is taken.
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid)
		else $error("result dropped before transfer");

	a_status_code: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (frame_status == STATUS_OK || frame_status == STATUS_HEADER
			|| frame_status == STATUS_CRC))
		else $error("undefined frame status");

	a_zero_on_err: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && frame_status != STATUS_OK |->
			temperature_tenths == 16'd0 && humidity_tenths == 16'd0)
		else $error("readings not zeroed on error");

	// A new result must follow a byte transfer on the input.
	a_out_source: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid) |-> $past(in_valid && in_ready, 2))
		else $error("result without a preceding byte transfer");

endmodule

bind sensor_response_frame_checker srfc_checker u_srfc_checker (
	.clk                (clk),
	.arst_n             (arst_n),
	.in_valid           (byte_in.valid),
	.in_ready           (byte_in.ready),
	.out_valid          (result_out.valid),
	.out_ready          (result_out.ready),
	.frame_status       (result_out.frame_status),
	.temperature_tenths (result_out.temperature_tenths),
	.humidity_tenths    (result_out.humidity_tenths)
);

`default_nettype wire

/* tb/tb.sv */
// Self-checking testbench for the sensor reply frame checker: directed table, then random frames.
`timescale 1ns / 1ps

module tb;
	import srfc_pkg::*;

	localparam int RANDOM_ITEMS  = 450;
	localparam int CYCLE_LIMIT   = 200000;
	localparam int SETTLE_CYCLES = 8;

	typedef struct packed {
		srfc_status_t status;
		logic [15:0]  temp_tenths;
		logic [15:0]  hum_tenths;
	} reading_t;

	// CRC bytes of a directed row are filled in from the running CRC when driven.
	typedef enum logic [1:0] {
		FILL_NONE,
		FILL_CRC_LO,
		FILL_CRC_LO_BAD,
		FILL_CRC_HI
	} crc_fill_t;

	typedef struct packed {
		logic [7:0] data_byte;
		logic       frame_start;
		crc_fill_t  fill;
		logic       typed;
		reading_t   want;
	} stim_row_t;

	localparam reading_t NO_READING = '{STATUS_OK, 16'd0, 16'd0};

	localparam int DIRECTED_ROWS = 25;

	stim_row_t directed_rows [DIRECTED_ROWS] = '{
		// bad first header byte, CRC also wrong: header fault wins
		'{8'hFF, 1'b1, FILL_NONE, 1'b0, NO_READING},
		'{8'h04, 1'b0, FILL_NONE, 1'b0, NO_READING},
		'{8'hFF, 1'b0, FILL_NONE, 1'b0, NO_READING},
		'{8'hFF, 1'b0, FILL_NONE, 1'b0, NO_READING},
		'{8'hFF, 1'b0, FILL_NONE, 1'b0, NO_READING},
		'{8'hFF, 1'b0, FILL_NONE, 1'b0, NO_READING},
		'{8'hFF, 1'b0, FILL_NONE, 1'b0, NO_READING},
		'{8'hFF, 1'b0, FILL_NONE, 1'b1, '{STATUS_HEADER, 16'd0, 16'd0}},
		// back-to-back frame without a start mark: full humidity, negative zero
		'{8'h03, 1'b0, FILL_NONE, 1'b0, NO_READING},
		'{8'h04, 1'b0, FILL_NONE, 1'b0, NO_READING},
		'{8'hFF, 1'b0, FILL_NONE, 1'b0, NO_READING},
		'{8'hFF, 1'b0, FILL_NONE, 1'b0, NO_READING},
		'{8'h80, 1'b0, FILL_NONE, 1'b0, NO_READING},
		'{8'h00, 1'b0, FILL_NONE, 1'b0, NO_READING},
		'{8'h00, 1'b0, FILL_CRC_LO, 1'b0, NO_READING},
		'{8'h00, 1'b0, FILL_CRC_HI, 1'b1, '{STATUS_OK, 16'd0, 16'hFFFF}},
		// partial frame, then a restart mid-frame into a frame with a bad CRC
		'{8'h03, 1'b1, FILL_NONE, 1'b0, NO_READING},
		'{8'h03, 1'b1, FILL_NONE, 1'b0, NO_READING},
		'{8'h04, 1'b0, FILL_NONE, 1'b0, NO_READING},
		'{8'h00, 1'b0, FILL_NONE, 1'b0, NO_READING},
		'{8'h00, 1'b0, FILL_NONE, 1'b0, NO_READING},
		'{8'hFF, 1'b0, FILL_NONE, 1'b0, NO_READING},
		'{8'hFF, 1'b0, FILL_NONE, 1'b0, NO_READING},
		'{8'h00, 1'b0, FILL_CRC_LO_BAD, 1'b0, NO_READING},
		'{8'h00, 1'b0, FILL_CRC_HI, 1'b1, '{STATUS_CRC, 16'd0, 16'd0}}
	};

	logic clk;
	logic arst_n;

	srfc_byte_if   byte_ch ();
	srfc_result_if result_ch ();

	sensor_response_frame_checker dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.byte_in   (byte_ch),
		.result_out(result_ch)
	);

	// Frame decoder state mirrored from the block.
	srfc_pos_t   model_pos;
	logic [15:0] model_crc;
	logic        model_hdr_bad;
	logic [15:0] model_hum;
	logic [15:0] model_tmp;
	logic [7:0]  model_crc_lo;

	reading_t pending_readings [$];

	int   err_count    = 0;
	int   bytes_sent   = 0;
	int   reports_seen = 0;
	int   ok_seen      = 0;
	int   hdr_seen     = 0;
	int   crc_seen     = 0;
	int   cycle_count  = 0;
	logic send_gaps    = 1'b1;
	logic drain_stalls = 1'b1;

	function automatic logic [15:0] crc16_step(input logic [15:0] crc, input logic [7:0] b);
		logic [15:0] c;
		logic        fb;
		c = crc;
		for (int i = 0; i < 8; i++) begin
			fb = c[0] ^ b[i];
			c  = c >> 1;
			if (fb) begin
				c = c ^ CRC_POLY;
			end
		end
		return c;
	endfunction

	// Advance the decoder by one byte; report a reading on the frame's last byte.
	function automatic void decode_byte(input logic [7:0] b, input logic s,
		output logic has_reading, output reading_t r);
		srfc_pos_t   p;
		logic [15:0] rx_crc;
		p           = s ? POS_HDR0 : model_pos;
		has_reading = 1'b0;
		r           = NO_READING;
		if (p == POS_HDR0) begin
			model_crc     = CRC_INIT;
			model_hdr_bad = 1'b0;
		end
		if (p <= POS_TMP_L) begin
			model_crc = crc16_step(model_crc, b);
		end
		case (p)
			POS_HDR0:  model_hdr_bad = (b != HEADER_BYTE0);
			POS_HDR1:  if (b != HEADER_BYTE1) model_hdr_bad = 1'b1;
			POS_HUM_H: model_hum[15:8] = b;
			POS_HUM_L: model_hum[7:0] = b;
			POS_TMP_H: model_tmp[15:8] = b;
			POS_TMP_L: model_tmp[7:0] = b;
			POS_CRC_L: model_crc_lo = b;
			default: ;
		endcase
		if (p != POS_CRC_H) begin
			model_pos = srfc_pos_t'(p + 3'd1);
		end else begin
			model_pos   = POS_HDR0;
			has_reading = 1'b1;
			rx_crc      = {b, model_crc_lo};
			if (model_hdr_bad) begin
				r.status = STATUS_HEADER;
			end else if (rx_crc != model_crc) begin
				r.status = STATUS_CRC;
			end else begin
				r.status      = STATUS_OK;
				r.hum_tenths  = model_hum;
				// sign-magnitude to two's complement; 0x8000 folds to zero
				r.temp_tenths = model_tmp[15] ? 16'(17'h10000 - {2'b00, model_tmp[14:0]})
					: {1'b0, model_tmp[14:0]};
			end
			model_crc = CRC_INIT;
		end
	endfunction

	task automatic push_byte(input logic [7:0] b, input logic s,
		output logic has_reading, output reading_t r);
		int gap;
		gap = send_gaps ? $urandom_range(0, 6) : 0;
		if (gap > 0) begin
			byte_ch.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		byte_ch.valid       <= 1'b1;
		byte_ch.data_byte   <= b;
		byte_ch.frame_start <= s;
		do @(posedge clk); while (byte_ch.ready !== 1'b1);
		bytes_sent++;
		decode_byte(b, s, has_reading, r);
	endtask

	task automatic drain_pending();
		byte_ch.valid <= 1'b0;
		@(posedge clk);
		while (pending_readings.size() != 0) @(posedge clk);
	endtask

	function automatic logic [7:0] pick_field_byte();
		case ($urandom_range(0, 5))
			0: return 8'h00;
			1: return 8'hFF;
			2: return 8'h80;
			3: return 8'h7F;
			default: return 8'($urandom_range(0, 255));
		endcase
	endfunction

	task automatic send_random_frame();
		logic [7:0]  fb [8];
		logic [15:0] crc_flip;
		logic        s;
		logic        got;
		reading_t    r;
		int          fault;
		fault    = $urandom_range(0, 9);
		crc_flip = 16'd0;
		fb[0]    = HEADER_BYTE0;
		fb[1]    = HEADER_BYTE1;
		for (int i = 2; i < 6; i++) begin
			fb[i] = pick_field_byte();
		end
		if (fault == 0) begin
			fb[0] ^= 8'($urandom_range(1, 255));
		end else if (fault == 1) begin
			fb[1] ^= 8'($urandom_range(1, 255));
		end else if (fault <= 3) begin
			crc_flip = 16'(1 << $urandom_range(0, 15));
		end
		for (int i = 0; i < 8; i++) begin
			// restart explicitly if a partial frame is still open
			s = 1'b0;
			if (i == 0) begin
				s = (model_pos != POS_HDR0) ? 1'b1 : 1'($urandom_range(0, 1));
			end
			if (i == 6) begin
				fb[6] = model_crc[7:0] ^ crc_flip[7:0];
			end
			if (i == 7) begin
				fb[7] = model_crc[15:8] ^ crc_flip[15:8];
			end
			push_byte(fb[i], s, got, r);
			if (got) begin
				pending_readings.push_back(r);
			end
		end
	endtask

	task automatic send_noise();
		int         n;
		logic [7:0] b;
		logic       s;
		logic       got;
		reading_t   r;
		n = $urandom_range(1, 7);
		for (int i = 0; i < n; i++) begin
			b = 8'($urandom_range(0, 255));
			s = ($urandom_range(0, 5) == 0);
			// half the bursts open like a real frame and then break off
			if (i == 0 && $urandom_range(0, 1) == 1) begin
				b = HEADER_BYTE0;
				s = 1'b1;
			end
			push_byte(b, s, got, r);
			if (got) begin
				pending_readings.push_back(r);
			end
		end
	endtask

	initial begin
		clk = 1'b0;
		forever #2 clk = ~clk;
	end

	initial begin
		while (cycle_count < CYCLE_LIMIT) begin
			@(posedge clk);
			cycle_count++;
		end
		$display("TB_ERROR");
		$finish;
	end

	// Result side: random stalls, check every transfer against the oldest reading.
	initial begin
		reading_t want;
		int       stall;
		result_ch.ready = 1'b0;
		@(posedge clk);
		forever begin
			stall = drain_stalls ? $urandom_range(0, 6) : 0;
			if (stall > 0) begin
				result_ch.ready <= 1'b0;
				repeat (stall) @(posedge clk);
			end
			result_ch.ready <= 1'b1;
			do @(posedge clk); while (result_ch.valid !== 1'b1);
			reports_seen++;
			case (result_ch.frame_status)
				STATUS_OK:     ok_seen++;
				STATUS_HEADER: hdr_seen++;
				default:       crc_seen++;
			endcase
			if (pending_readings.size() == 0) begin
				$error("result transfer with no reading expected: status %0d",
					result_ch.frame_status);
				err_count++;
			end else begin
				want = pending_readings.pop_front();
				if (result_ch.frame_status !== want.status) begin
					$error("frame_status: expected %0d, got %0d",
						want.status, result_ch.frame_status);
					err_count++;
				end
				if (result_ch.temperature_tenths !== want.temp_tenths) begin
					$error("temperature_tenths: expected %0d, got %0d",
						$signed(want.temp_tenths), result_ch.temperature_tenths);
					err_count++;
				end
				if (result_ch.humidity_tenths !== want.hum_tenths) begin
					$error("humidity_tenths: expected %0d, got %0d",
						want.hum_tenths, result_ch.humidity_tenths);
					err_count++;
				end
			end
		end
	end

	initial begin
		stim_row_t  row;
		logic [7:0] b;
		logic       got;
		reading_t   r;
		int         frames;
		arst_n              = 1'b0;
		byte_ch.valid       = 1'b0;
		byte_ch.data_byte   = 8'h00;
		byte_ch.frame_start = 1'b0;
		model_pos           = POS_HDR0;
		model_crc           = CRC_INIT;
		model_hdr_bad       = 1'b0;
		model_hum           = 16'd0;
		model_tmp           = 16'd0;
		model_crc_lo        = 8'd0;
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;

		for (int i = 0; i < DIRECTED_ROWS; i++) begin
			row = directed_rows[i];
			b   = row.data_byte;
			case (row.fill)
				FILL_CRC_LO:     b = model_crc[7:0];
				FILL_CRC_LO_BAD: b = model_crc[7:0] ^ 8'h01;
				FILL_CRC_HI:     b = model_crc[15:8];
				default: ;
			endcase
			push_byte(b, row.frame_start, got, r);
			if (got) begin
				pending_readings.push_back(row.typed ? row.want : r);
			end
		end
		drain_pending();

		frames = 0;
		while (bytes_sent < DIRECTED_ROWS + RANDOM_ITEMS) begin
			if (frames % 12 == 0) begin
				// second block runs with no idling on either side
				if (frames / 12 == 1) begin
					send_gaps    = 1'b0;
					drain_stalls = 1'b0;
				end else begin
					send_gaps    = ($urandom_range(0, 3) != 0);
					drain_stalls = ($urandom_range(0, 3) != 0);
				end
			end
			if ($urandom_range(0, 9) < 8) begin
				send_random_frame();
			end else begin
				send_noise();
			end
			frames++;
			if (frames == 30) begin
				drain_pending();
			end
		end

		drain_pending();
		repeat (SETTLE_CYCLES) @(posedge clk);
		$display("Sent %0d bytes; checked %0d frame reports (%0d ok, %0d header, %0d CRC).",
			bytes_sent, reports_seen, ok_seen, hdr_seen, crc_seen);
		$display("Covered restarts, back-to-back frames, noise bursts and idle/stall phases.");
		if (err_count == 0) begin
			$display("TB_OK");
		end else begin
			$display("TB_ERROR");
		end
		$finish;
	end

endmodule
